[rtl/brainfuck_instruction_engine_assert.svh]
`ifndef BRAINFUCK_INSTRUCTION_ENGINE_ASSERT_SVH
`define BRAINFUCK_INSTRUCTION_ENGINE_ASSERT_SVH

// condition must never hold outside reset
`define BFIE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BFIE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bfie_pkg.sv]
`timescale 1ns / 1ps
package bfie_pkg;

    localparam int LA_W      = 12;
    localparam int BYTE_W    = 8;
    localparam int CFG_LEN_W = 13;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;

    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EXEC    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    localparam logic [STAT_W-1:0] ST_RUN       = 2'd0;
    localparam logic [STAT_W-1:0] ST_END       = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNMATCHED = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

[rtl/bfie_ram.sv]
`timescale 1ns / 1ps
module bfie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfie_alu.sv]
`timescale 1ns / 1ps
module bfie_alu #(
    parameter int W = 18
) (
    input  bfie_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [W-1:0]      i_c,
    output logic [W-1:0]      o_res,
    output logic              o_ge,
    output logic              o_lt
);

    import bfie_pkg::*;

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a + i_b;
        endcase
    end

    assign o_ge = (o_res >= i_c);
    assign o_lt = (i_a < i_b);

endmodule

[rtl/brainfuck_instruction_engine.sv]
// Execute word: after accept the states execute, advance and result; a halted or ended program goes straight to result;
// a forward bracket skip adds a store read and a check state per scanned program byte.
// Load word: the address reduction steps through the shared adder, then the store write and the result
// (no reduction steps when PROGRAM_DEPTH >= 4096). Restart word: a tape clearing pass, then the result.
// Reset: control cleared at once, then a clearing pass over all TAPE_DEPTH tape cells, not ready.
// Next word taken in the cycle after its result loads; the result may wait on the output.
`timescale 1ns / 1ps
`include "brainfuck_instruction_engine_assert.svh"
module brainfuck_instruction_engine #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH    = 32768,
    parameter int STACK_DEPTH   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] load_address, [19:12] program_byte, [27:20] input_byte, [31:28] zero
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    // [0] out_valid, [1] input_taken, [3:2] status
    output logic [3:0]  o_m_axis_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    import bfie_pkg::*;

    function automatic int mod_steps(input int depth);
        int n;
        n = 0;
        for (int k = 0; k < LA_W; k++) begin
            if ((longint'(depth) << k) <= longint'((1 << LA_W) - 1)) begin
                n++;
            end
        end
        return n;
    endfunction

    localparam int PA_W      = $clog2(PROGRAM_DEPTH);
    localparam int PC_W      = $clog2(PROGRAM_DEPTH + 1);
    localparam int TP_W      = $clog2(TAPE_DEPTH);
    localparam int TP1_W     = $clog2(TAPE_DEPTH + 1);
    localparam int SA_W      = $clog2(STACK_DEPTH);
    localparam int SD_W      = $clog2(STACK_DEPTH + 1);
    localparam int LIM_W     = (PC_W > CFG_LEN_W) ? PC_W : CFG_LEN_W;
    localparam int AW        = ((LIM_W > TP1_W) ? LIM_W : TP1_W) + 1;
    localparam int MOD_STEPS = mod_steps(PROGRAM_DEPTH);
    localparam int KW        = $clog2(LA_W);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_EXEC     = 4'd2;
    localparam logic [3:0] S_ADV      = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_LMOD     = 4'd6;
    localparam logic [3:0] S_LOAD     = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [TP_W-1:0]      r_clr, n_clr;
    logic                 r_clr_resp, n_clr_resp;
    logic [PC_W-1:0]      r_pc, n_pc;
    logic [TP_W-1:0]      r_dp, n_dp;
    logic [SD_W-1:0]      r_depth, n_depth;
    logic [STAT_W-1:0]    r_halt, n_halt;
    logic [PC_W-1:0]      r_scan, n_scan;
    logic [PC_W-1:0]      r_nest, n_nest;
    logic [PC_W-1:0]      r_base, n_base;
    logic [LA_W-1:0]      r_lad, n_lad;
    logic [KW-1:0]        r_k, n_k;
    logic [BYTE_W-1:0]    r_pbyte, n_pbyte;
    logic [BYTE_W-1:0]    r_ibyte, n_ibyte;
    logic [BYTE_W-1:0]    r_rbyte, n_rbyte;
    logic                 r_rvalid, n_rvalid;
    logic                 r_rtaken, n_rtaken;
    logic [CFG_LEN_W-1:0] r_len;

    logic                 r_ov;
    logic [BYTE_W-1:0]    r_obyte;
    logic                 r_ovld;
    logic                 r_otaken;
    logic [STAT_W-1:0]    r_ostat;

    logic [LIM_W-1:0]     w_limit;
    logic [ACT_W-1:0]     w_act;
    logic                 w_resp_load;

    t_alu_op              alu_op;
    logic [AW-1:0]        alu_a, alu_b, alu_c, alu_res;
    logic                 alu_ge, alu_lt;

    logic                 prog_we;
    logic [PA_W-1:0]      prog_waddr, prog_raddr;
    logic [BYTE_W-1:0]    prog_wdata, prog_rdata;
    logic                 tape_we;
    logic [TP_W-1:0]      tape_waddr;
    logic [BYTE_W-1:0]    tape_wdata, tape_rdata;
    logic                 stk_we;
    logic [SA_W-1:0]      stk_waddr, stk_raddr;
    logic [PA_W-1:0]      stk_wdata, stk_rdata;
    logic [SD_W-1:0]      w_depth_m1;

    assign w_limit = (LIM_W'(r_len) < LIM_W'(PROGRAM_DEPTH)) ? LIM_W'(r_len)
                                                            : LIM_W'(PROGRAM_DEPTH);
    assign w_act      = i_s_axis_tuser;
    assign w_depth_m1 = r_depth - 1'b1;
    assign stk_raddr  = w_depth_m1[SA_W-1:0];

    bfie_alu #(.W(AW)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_res (alu_res),
        .o_ge  (alu_ge),
        .o_lt  (alu_lt)
    );

    bfie_ram #(.WIDTH(BYTE_W), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    bfie_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_dp),
        .o_rdata (tape_rdata)
    );

    bfie_ram #(.WIDTH(PA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_clr_resp = r_clr_resp;
        n_pc       = r_pc;
        n_dp       = r_dp;
        n_depth    = r_depth;
        n_halt     = r_halt;
        n_scan     = r_scan;
        n_nest     = r_nest;
        n_base     = r_base;
        n_lad      = r_lad;
        n_k        = r_k;
        n_pbyte    = r_pbyte;
        n_ibyte    = r_ibyte;
        n_rbyte    = r_rbyte;
        n_rvalid   = r_rvalid;
        n_rtaken   = r_rtaken;

        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        alu_c  = AW'(w_limit);

        prog_we    = 1'b0;
        prog_waddr = PA_W'(r_lad);
        prog_wdata = r_pbyte;
        prog_raddr = r_pc[PA_W-1:0];
        tape_we    = 1'b0;
        tape_waddr = r_dp;
        tape_wdata = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_depth[SA_W-1:0];
        stk_wdata  = r_pc[PA_W-1:0];

        case (r_state)
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == TP_W'(TAPE_DEPTH - 1)) begin
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                alu_a = AW'(r_pc);
                if (i_s_axis_tvalid) begin
                    n_lad    = i_s_axis_tdata[LA_W-1:0];
                    n_pbyte  = i_s_axis_tdata[LA_W +: BYTE_W];
                    n_ibyte  = i_s_axis_tdata[LA_W+BYTE_W +: BYTE_W];
                    n_rbyte  = '0;
                    n_rvalid = 1'b0;
                    n_rtaken = 1'b0;
                    case (w_act)
                        ACT_LOAD: begin
                            if (MOD_STEPS == 0) begin
                                n_state = S_LOAD;
                            end else begin
                                n_k     = KW'(MOD_STEPS - 1);
                                n_state = S_LMOD;
                            end
                        end
                        ACT_EXEC: begin
                            if (r_halt != ST_RUN) begin
                                n_state = S_RESP;
                            end else if (alu_ge) begin
                                n_halt  = ST_END;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        ACT_RESTART: begin
                            n_pc       = '0;
                            n_dp       = '0;
                            n_depth    = '0;
                            n_halt     = ST_RUN;
                            n_clr      = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_base  = r_pc;
                n_state = S_ADV;
                case (prog_rdata)
                    CMD_RIGHT: begin
                        alu_a = AW'(r_dp);
                        alu_b = AW'(1);
                        alu_c = AW'(TAPE_DEPTH);
                        n_dp  = alu_ge ? '0 : alu_res[TP_W-1:0];
                    end
                    CMD_LEFT: begin
                        alu_op = ALU_SUB;
                        alu_a  = (r_dp == '0) ? AW'(TAPE_DEPTH) : AW'(r_dp);
                        alu_b  = AW'(1);
                        n_dp   = alu_res[TP_W-1:0];
                    end
                    CMD_INC: begin
                        alu_a      = AW'(tape_rdata);
                        alu_b      = AW'(1);
                        tape_we    = 1'b1;
                        tape_wdata = alu_res[BYTE_W-1:0];
                    end
                    CMD_DEC: begin
                        alu_op     = ALU_SUB;
                        alu_a      = AW'(tape_rdata);
                        alu_b      = AW'(1);
                        tape_we    = 1'b1;
                        tape_wdata = alu_res[BYTE_W-1:0];
                    end
                    CMD_OUT: begin
                        n_rbyte  = tape_rdata;
                        n_rvalid = 1'b1;
                    end
                    CMD_IN: begin
                        tape_we    = 1'b1;
                        tape_wdata = r_ibyte;
                        n_rtaken   = 1'b1;
                    end
                    CMD_OPEN: begin
                        if (tape_rdata != '0) begin
                            if (r_depth >= SD_W'(STACK_DEPTH)) begin
                                n_halt  = ST_OVERFLOW;
                                n_state = S_RESP;
                            end else begin
                                stk_we  = 1'b1;
                                n_depth = r_depth + 1'b1;
                            end
                        end else begin
                            alu_a   = AW'(r_pc);
                            alu_b   = AW'(1);
                            n_scan  = alu_res[PC_W-1:0];
                            n_nest  = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    CMD_CLOSE: begin
                        if (r_depth == '0) begin
                            n_halt  = ST_UNMATCHED;
                            n_state = S_RESP;
                        end else if (tape_rdata != '0) begin
                            n_base = PC_W'(stk_rdata);
                        end else begin
                            n_depth = w_depth_m1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ADV: begin
                alu_a   = AW'(r_base);
                alu_b   = AW'(1);
                n_pc    = alu_res[PC_W-1:0];
                n_state = S_RESP;
                if (alu_ge) begin
                    n_halt = ST_END;
                end
            end
            S_SCAN_RD: begin
                alu_a      = AW'(r_scan);
                prog_raddr = r_scan[PA_W-1:0];
                if (alu_ge) begin
                    n_halt  = ST_UNMATCHED;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                alu_a   = AW'(r_scan);
                alu_b   = AW'(1);
                n_scan  = alu_res[PC_W-1:0];
                n_state = S_SCAN_RD;
                if (prog_rdata == CMD_OPEN) begin
                    n_nest = r_nest + 1'b1;
                end else if (prog_rdata == CMD_CLOSE) begin
                    if (r_nest == '0) begin
                        n_base  = r_scan;
                        n_state = S_ADV;
                    end else begin
                        n_nest = r_nest - 1'b1;
                    end
                end
            end
            S_LMOD: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_lad);
                alu_b  = AW'(PROGRAM_DEPTH) << r_k;
                if (!alu_lt) begin
                    n_lad = alu_res[LA_W-1:0];
                end
                if (r_k == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_LOAD: begin
                prog_we = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_ov || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_clr_resp <= 1'b0;
            r_pc       <= '0;
            r_dp       <= '0;
            r_depth    <= '0;
            r_halt     <= ST_RUN;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_clr_resp <= n_clr_resp;
            r_pc       <= n_pc;
            r_dp       <= n_dp;
            r_depth    <= n_depth;
            r_halt     <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_nest   <= n_nest;
        r_base   <= n_base;
        r_lad    <= n_lad;
        r_k      <= n_k;
        r_pbyte  <= n_pbyte;
        r_ibyte  <= n_ibyte;
        r_rbyte  <= n_rbyte;
        r_rvalid <= n_rvalid;
        r_rtaken <= n_rtaken;
    end

    assign w_resp_load = (r_state == S_RESP) && (!r_ov || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_resp_load) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_resp_load) begin
            r_obyte  <= r_rbyte;
            r_ovld   <= r_rvalid;
            r_otaken <= r_rtaken;
            r_ostat  <= r_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_PROGRAM_LENGTH)) begin
            r_len <= i_pwdata[CFG_LEN_W-1:0];
        end
    end

    assign o_prdata        = (i_paddr[2] == REG_PROGRAM_LENGTH) ? 32'(r_len) : '0;
    assign o_pready        = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tuser  = {r_ostat, r_otaken, r_ovld};

    `BFIE_ASSERT_IMPLIES(a_clear_busy, i_clk, i_rst_n, r_state == S_CLEAR, !o_s_axis_tready, "word accepted during tape clear")
    `BFIE_ASSERT_NEVER(a_depth_bound, i_clk, i_rst_n, r_depth > SD_W'(STACK_DEPTH), "bracket stack depth beyond its size")
    `BFIE_ASSERT_NEVER(a_pc_bound, i_clk, i_rst_n, r_pc > PC_W'(PROGRAM_DEPTH), "program counter beyond program store")
    `BFIE_ASSERT_NEXT(a_halt_hold, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (w_act == ACT_EXEC) && (r_halt != ST_RUN), $stable(r_pc) && $stable(r_halt), "halted engine changed state on execute")

endmodule

[tb/bf_engine_checker.sv]
`timescale 1ns / 1ps
module bf_engine_checker #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH    = 32768,
    parameter int STACK_DEPTH   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [11:0] load_address, [19:12] program_byte, [27:20] input_byte, [31:28] zero
    input  logic [31:0] i_s_tdata,
    // [1:0] action
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_byte
    input  logic [7:0]  i_m_tdata,
    // [0] out_valid, [1] input_taken, [3:2] status
    input  logic [3:0]  i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_pending,
    output int          o_fail_count
);
    import bfie_pkg::*;

    localparam int DP_W = $clog2(TAPE_DEPTH);
    localparam int SD_W = $clog2(STACK_DEPTH + 1);
    localparam logic [2:0] LEN_ADDR = {REG_PROGRAM_LENGTH, 2'b00};

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              input_taken;
        logic [STAT_W-1:0] status;
    } engine_reply_t;

    logic [BYTE_W-1:0]    code_mem   [PROGRAM_DEPTH];
    logic [BYTE_W-1:0]    tape_mem   [TAPE_DEPTH];
    logic [LA_W-1:0]      open_addrs [STACK_DEPTH];
    logic [CFG_LEN_W-1:0] prog_len;
    logic [CFG_LEN_W-1:0] pc;
    logic [DP_W-1:0]      dp;
    logic [SD_W-1:0]      depth;
    logic [STAT_W-1:0]    halt_code;
    engine_reply_t        replies_due [$];
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void clear_machine();
        foreach (tape_mem[i]) tape_mem[i] = '0;
        pc        = '0;
        dp        = '0;
        depth     = '0;
        halt_code = ST_RUN;
    endfunction

    function automatic engine_reply_t execute_word(input logic [ACT_W-1:0] act,
                                                   input logic [LA_W-1:0] addr,
                                                   input logic [BYTE_W-1:0] pbyte,
                                                   input logic [BYTE_W-1:0] ibyte);
        engine_reply_t        r;
        logic [CFG_LEN_W-1:0] lim;
        logic [CFG_LEN_W-1:0] nxt;
        logic [BYTE_W-1:0]    op;
        int                   nest;
        int                   scan;
        int                   match;
        r   = '0;
        lim = (prog_len < PROGRAM_DEPTH) ? prog_len : CFG_LEN_W'(PROGRAM_DEPTH);
        if (act == ACT_LOAD) begin
            code_mem[addr] = pbyte;
        end else if (act == ACT_RESTART) begin
            clear_machine();
        end else if (act == ACT_EXEC && halt_code == ST_RUN) begin
            if (pc >= lim) begin
                halt_code = ST_END;
            end else begin
                op  = code_mem[pc];
                nxt = pc + 1'b1;
                case (op)
                    CMD_RIGHT: dp = DP_W'((dp + 1) % TAPE_DEPTH);
                    CMD_LEFT:  dp = DP_W'((dp + TAPE_DEPTH - 1) % TAPE_DEPTH);
                    CMD_INC:   tape_mem[dp] = tape_mem[dp] + 1'b1;
                    CMD_DEC:   tape_mem[dp] = tape_mem[dp] - 1'b1;
                    CMD_OUT: begin
                        r.out_byte  = tape_mem[dp];
                        r.out_valid = 1'b1;
                    end
                    CMD_IN: begin
                        tape_mem[dp]  = ibyte;
                        r.input_taken = 1'b1;
                    end
                    CMD_OPEN: begin
                        if (tape_mem[dp] != 0) begin
                            if (depth >= STACK_DEPTH) begin
                                halt_code = ST_OVERFLOW;
                            end else begin
                                open_addrs[depth] = pc[LA_W-1:0];
                                depth = depth + 1'b1;
                            end
                        end else begin
                            nest  = 0;
                            match = -1;
                            for (scan = pc + 1; scan < int'(lim) && match < 0; scan++) begin
                                if (code_mem[scan] == CMD_OPEN) begin
                                    nest++;
                                end else if (code_mem[scan] == CMD_CLOSE) begin
                                    if (nest == 0) match = scan;
                                    else nest--;
                                end
                            end
                            if (match < 0) halt_code = ST_UNMATCHED;
                            else nxt = CFG_LEN_W'(match + 1);
                        end
                    end
                    CMD_CLOSE: begin
                        if (depth == 0) begin
                            halt_code = ST_UNMATCHED;
                        end else if (tape_mem[dp] != 0) begin
                            nxt = CFG_LEN_W'(open_addrs[depth - 1]) + 1'b1;
                        end else begin
                            depth = depth - 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (halt_code == ST_RUN) begin
                    pc = nxt;
                    if (pc >= lim) halt_code = ST_END;
                end
            end
        end
        r.status = halt_code;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        engine_reply_t got;
        engine_reply_t want;
        if (!i_rst_n) begin
            clear_machine();
            prog_len = '0;
            replies_due.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata, i_m_tuser[0], i_m_tuser[1], i_m_tuser[3:2]};
                if (replies_due.size() == 0) begin
                    $error("unexpected result word: out_byte %0h, status %0d",
                           got.out_byte, got.status);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("out_valid", want.out_valid, got.out_valid);
                    check_field("input_taken", want.input_taken, got.input_taken);
                    check_field("status", want.status, got.status);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(execute_word(i_s_tuser, i_s_tdata[11:0],
                                                   i_s_tdata[19:12], i_s_tdata[27:20]));
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LEN_ADDR) begin
                prog_len = i_pwdata[CFG_LEN_W-1:0];
            end
            o_pending <= replies_due.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import bfie_pkg::*;

    localparam int PROGRAM_DEPTH  = 4096;
    localparam int TAPE_DEPTH     = 32768;
    localparam int STACK_DEPTH    = 64;
    localparam int ITEM_TARGET    = 1500;
    localparam int PHASES         = 60;
    localparam int RUN_WORDS      = 150;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;
    localparam logic [2:0]       LEN_ADDR = {REG_PROGRAM_LENGTH, 2'b00};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        gaps_on  = 1'b1;
    logic [STAT_W-1:0] last_status = ST_RUN;
    int          pending;
    int          fails;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    logic [7:0]  prog_buf [$];
    logic [7:0]  demo_prog [16] = '{CMD_IN, CMD_OUT, CMD_LEFT, CMD_OUT, CMD_RIGHT, CMD_INC,
                                    CMD_OPEN, CMD_OPEN, CMD_CLOSE, CMD_CLOSE, CMD_DEC,
                                    CMD_OPEN, CMD_IN, CMD_CLOSE, 8'h00, CMD_CLOSE};

    brainfuck_instruction_engine #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    bf_engine_checker #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
    end

    always @(posedge clk) begin
        if (m_tvalid && m_tready) last_status <= m_tuser[3:2];
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [11:0] addr,
                             input logic [7:0] pbyte, input logic [7:0] ibyte);
        while (gaps_on && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, ibyte, pbyte, addr};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_length(input logic [12:0] len);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LEN_ADDR;
        pwdata  <= 32'(len);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(9))
            0:       return CMD_RIGHT;
            1:       return CMD_LEFT;
            2, 3:    return CMD_INC;
            4, 5:    return CMD_DEC;
            6:       return CMD_OUT;
            7:       return CMD_IN;
            8:       return CMD_OPEN;
            default: return CMD_CLOSE;
        endcase
    endfunction

    initial begin
        int         phase;
        int         len;
        int         prog_len;
        int         open_cnt;
        int         post_halt;
        int         n;
        int         r;
        logic [7:0] b;
        bit         broken;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_length(13'd16);
        foreach (demo_prog[i]) send_word(ACT_LOAD, 12'(i), demo_prog[i], 8'($urandom));
        send_word(ACT_EXEC, 12'($urandom), 8'($urandom), 8'hFF);
        repeat (13) send_word(ACT_EXEC, 12'($urandom), 8'($urandom), 8'h00);
        send_word(ACT_LOAD, 12'hFFF, 8'hFF, 8'h00);
        send_word(ACT_NOP, 12'h000, 8'h00, 8'hFF);

        for (phase = 0; phase < PHASES && items_sent < ITEM_TARGET; phase++) begin
            prog_buf.delete();
            if (phase == 0) begin
                prog_len = 0;
            end else if (phase == 1) begin
                prog_buf = '{CMD_OPEN, CMD_CLOSE, CMD_CLOSE};
                prog_len = PROGRAM_DEPTH;
            end else if (phase == 2) begin
                prog_buf.push_back(CMD_INC);
                repeat (STACK_DEPTH + 1) prog_buf.push_back(CMD_OPEN);
                prog_len = prog_buf.size();
            end else begin
                len      = $urandom_range(3, 40);
                broken   = ($urandom_range(3) == 0);
                open_cnt = 0;
                for (n = 0; n < len; n++) begin
                    if (broken) begin
                        b = $urandom_range(1) ? pick_command() : 8'($urandom);
                    end else if (open_cnt >= len - n) begin
                        b = CMD_CLOSE;
                    end else begin
                        b = pick_command();
                        if (b == CMD_OPEN && open_cnt + 2 > len - n) b = CMD_DEC;
                        if (b == CMD_CLOSE && open_cnt == 0) b = CMD_INC;
                        if ($urandom_range(15) == 0) begin
                            b = 8'($urandom);
                            if (b == CMD_OPEN || b == CMD_CLOSE) b = 8'h00;
                        end
                    end
                    if (b == CMD_OPEN) open_cnt++;
                    else if (b == CMD_CLOSE) open_cnt--;
                    prog_buf.push_back(b);
                end
                prog_len = ($urandom_range(3) == 0) ? $urandom_range(1, len) : len;
            end

            foreach (prog_buf[i]) send_word(ACT_LOAD, 12'(i), prog_buf[i], 8'($urandom));
            gaps_on <= (phase % 6 != 4);
            write_length(13'(prog_len));
            send_word(ACT_RESTART, 12'($urandom), 8'($urandom), 8'($urandom));
            drain();

            post_halt = 0;
            for (n = 0; n < RUN_WORDS && post_halt < 4; n++) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    send_word(ACT_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
                end else if (r < 90 && phase > 2) begin
                    if ($urandom_range(1))
                        send_word(ACT_LOAD, 12'($urandom_range(prog_buf.size() - 1)),
                                  pick_command(), 8'($urandom));
                    else
                        send_word(ACT_LOAD, 12'($urandom), 8'($urandom), 8'($urandom));
                end else if (r < 97) begin
                    send_word(ACT_NOP, 12'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    drain();
                end
                if (last_status != ST_RUN) post_halt++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bfie_pkg.sv
rtl/bfie_ram.sv
rtl/bfie_alu.sv
rtl/brainfuck_instruction_engine.sv
tb/bf_engine_checker.sv
tb/testbench.sv
